// File: design/pnth_pkg.sv
`default_nettype none

package pnth_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REGION,
    ST_CHECK,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [2:0] CFG_GRID_CENTER_X       = 3'd0;
  localparam logic [2:0] CFG_GRID_TOP_Y          = 3'd1;
  localparam logic [2:0] CFG_DIAMOND_HALF_EXTENT = 3'd2;
  localparam logic [2:0] CFG_HIT_RADIUS          = 3'd3;
  localparam logic [2:0] CFG_TILES_IN_USE        = 3'd4;

  typedef struct packed {
    logic       start;
    logic [6:0] limit;
  } scan_ctrl_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic [5:0]  best_idx;
    logic [16:0] best_dist;
  } scan_res_t;

endpackage

`default_nettype wire

// File: design/pnth_scan.sv
`default_nettype none

module pnth_scan import pnth_pkg::*; #(
  parameter int TILE_COUNT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [5:0]         wr_slot,
  input  wire logic signed [15:0] wr_x,
  input  wire logic signed [15:0] wr_y,
  input  wire logic signed [15:0] px,
  input  wire logic signed [15:0] py,
  input  wire scan_ctrl_t         ctrl,
  output scan_res_t               res
);

  localparam int AW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;

  // Tile centres, y in the upper half and x in the lower half of each entry.
  logic [31:0] mem [TILE_COUNT];

  logic        busy;
  logic [6:0]  issue_idx;
  logic [6:0]  limit_r;
  logic        issuing;
  logic [31:0] rd_data;
  logic        rd_valid;
  logic [5:0]  rd_idx;
  logic        s1_valid;
  logic [5:0]  s1_idx;
  logic [15:0] s1_dx;
  logic [15:0] s1_dy;
  logic        found;
  logic [5:0]  best_idx;
  logic [16:0] best_dist;
  logic        done;

  logic signed [16:0] xd;
  logic signed [16:0] yd;
  logic [16:0]        sum;

  assign issuing = busy && (issue_idx < limit_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_slot)] <= {wr_y, wr_x};
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      rd_data <= mem[AW'(issue_idx)];
    end
  end

  assign xd  = 17'(signed'(rd_data[15:0])) - 17'(px);
  assign yd  = 17'(signed'(rd_data[31:16])) - 17'(py);
  assign sum = 17'(s1_dx) + 17'(s1_dy);

  always_ff @(posedge clk) begin
    s1_idx <= rd_idx;
    s1_dx  <= xd[16] ? 16'(-xd) : 16'(xd);
    s1_dy  <= yd[16] ? 16'(-yd) : 16'(yd);
    if (issuing) begin
      rd_idx <= 6'(issue_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issue_idx <= '0;
      limit_r   <= '0;
      rd_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      found     <= 1'b0;
      best_idx  <= '0;
      best_dist <= '0;
      done      <= 1'b0;
    end else begin
      rd_valid <= issuing;
      s1_valid <= rd_valid;
      done     <= 1'b0;
      if (ctrl.start) begin
        busy      <= 1'b1;
        issue_idx <= '0;
        limit_r   <= ctrl.limit;
        found     <= 1'b0;
        best_idx  <= '0;
        best_dist <= '0;
      end else if (busy) begin
        if (issuing) begin
          issue_idx <= issue_idx + 7'd1;
        end
        // The pipeline has drained once nothing is issued or in flight.
        if (!issuing && !rd_valid && !s1_valid) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      // Entries arrive in ascending order, so a strict compare keeps the lowest index on a tie.
      if (s1_valid && (!found || sum < best_dist)) begin
        found     <= 1'b1;
        best_idx  <= s1_idx;
        best_dist <= sum;
      end
    end
  end

  assign res.done      = done;
  assign res.found     = found;
  assign res.best_idx  = best_idx;
  assign res.best_dist = best_dist;

endmodule

`default_nettype wire

// File: design/pointer_nearest_tile_hit_test.sv
// Channel   Direction  Word
// s_*       in         tuser: command; tdata: tile_slot, center_x, center_y, pointer_x, pointer_y
// m_*       out        tdata: in_region, nearest_tile, nearest_distance, pointing,
//                      highlighted_tile, hover_cue
// cfg_*     in         register index and data, written at once
//
// A load gives no result. A query inside the region walks N table entries, where N is
// the number of tiles searched: the centre table has a single read port and is walked one
// entry a cycle through a two-stage distance unit.
// Reset is synchronous and clears the registers, the highlight and the cue flag.
// The finished word waits in the output register; only if a second query completes before
// it is taken does the block hold that query and stay not ready.
`default_nettype none

module pointer_nearest_tile_hit_test import pnth_pkg::*; #(
  parameter int TILE_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tile_slot[5:0], center_x[21:6], center_y[37:22], pointer_x[53:38], pointer_y[69:54]
  input  wire logic [71:0] s_tdata,
  // command[0]
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // in_region[0], nearest_tile[6:1], nearest_distance[23:7], pointing[24],
  // highlighted_tile[30:25], hover_cue[31]
  output logic [31:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic signed [15:0] grid_center_x;
  logic signed [15:0] grid_top_y;
  logic [14:0]        diamond_half_extent;
  logic [14:0]        hit_radius;
  logic [6:0]         tiles_in_use;

  logic [5:0]         highlight_index;
  logic               cue_given;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [15:0]        reg_dx;
  logic [16:0]        reg_dy;
  logic               in_region;

  logic [5:0]         tile_slot;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic               accept;
  logic               wr_en;

  logic signed [16:0] cy;
  logic signed [17:0] dyf;
  logic signed [16:0] dxf;
  logic               in_diamond;

  scan_ctrl_t         ctrl;
  scan_res_t          res;
  logic               out_load;
  logic [6:0]         limit;

  logic [5:0]         highlight_index_next;
  logic               cue_given_next;
  logic               pointing;
  logic               hover;

  assign tile_slot = s_tdata[5:0];
  assign center_x  = signed'(s_tdata[21:6]);
  assign center_y  = signed'(s_tdata[37:22]);
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && (s_tuser == CMD_LOAD) && (32'(tile_slot) < TILE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_center_x       <= '0;
      grid_top_y          <= '0;
      diamond_half_extent <= '0;
      hit_radius          <= '0;
      tiles_in_use        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_CENTER_X:       grid_center_x       <= signed'(cfg_data);
        CFG_GRID_TOP_Y:          grid_top_y          <= signed'(cfg_data);
        CFG_DIAMOND_HALF_EXTENT: diamond_half_extent <= cfg_data[14:0];
        CFG_HIT_RADIUS:          hit_radius          <= cfg_data[14:0];
        CFG_TILES_IN_USE:        tiles_in_use        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Region test: inside when |dx| + |dy| stays within the half extent.
  assign cy         = 17'(grid_top_y) + signed'(17'(diamond_half_extent));
  assign dyf        = 18'(py) - 18'(cy);
  assign dxf        = 17'(px) - 17'(grid_center_x);
  assign in_diamond = (18'(reg_dx) + 18'(reg_dy)) <= 18'(diamond_half_extent);

  always_ff @(posedge clk) begin
    if (accept && s_tuser == CMD_QUERY) begin
      px <= signed'(s_tdata[53:38]);
      py <= signed'(s_tdata[69:54]);
    end
    if (state == ST_REGION) begin
      reg_dx <= dxf[16] ? 16'(-dxf) : 16'(dxf);
      reg_dy <= dyf[17] ? 17'(-dyf) : 17'(dyf);
    end
    if (state == ST_CHECK) begin
      in_region <= in_diamond;
    end
  end

  assign limit = (32'(tiles_in_use) > TILE_COUNT) ? 7'(TILE_COUNT) : tiles_in_use;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && s_tuser == CMD_QUERY) state_next = ST_REGION;
      ST_REGION: state_next = ST_CHECK;
      ST_CHECK:  state_next = in_diamond ? ST_SCAN : ST_FINISH;
      ST_SCAN:   if (res.done) state_next = ST_FINISH;
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = (state == ST_IDLE);
    ctrl.start = (state == ST_CHECK) && in_diamond;
    ctrl.limit = limit;
    out_load   = (state == ST_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  pnth_scan #(
    .TILE_COUNT(TILE_COUNT)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_slot (tile_slot),
    .wr_x    (center_x),
    .wr_y    (center_y),
    .px      (px),
    .py      (py),
    .ctrl    (ctrl),
    .res     (res)
  );

  // A closest tile that differs from the highlight re-arms the cue even when out of reach.
  always_comb begin
    highlight_index_next = highlight_index;
    cue_given_next       = cue_given;
    pointing             = 1'b0;
    hover                = 1'b0;
    if (in_region && res.found) begin
      if (res.best_idx != highlight_index) begin
        cue_given_next = 1'b0;
      end
      if (res.best_dist <= 17'(hit_radius)) begin
        highlight_index_next = res.best_idx;
        pointing             = 1'b1;
        if (!cue_given_next) begin
          hover          = 1'b1;
          cue_given_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highlight_index <= '0;
      cue_given       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (out_load) begin
        highlight_index <= highlight_index_next;
        cue_given       <= cue_given_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {hover, highlight_index_next, pointing,
                  in_region ? res.best_dist : 17'd0,
                  in_region ? res.best_idx : 6'd0,
                  in_region};
    end
  end

endmodule

`default_nettype wire

// File: design/pnth_checker.sv
`default_nettype none

module pnth_checker import pnth_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // A word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // A query occupies the block, so the next cycle cannot take another word.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_QUERY) |=> !s_tready)
    else $error("ready right after a query");

  // Outside the region nothing is searched and no cue is given.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[24:1] == 24'd0) && !m_tdata[31])
    else $error("search fields set outside the region");

  // Pointing at a tile makes it the highlighted one.
  a_point_highlight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[24] |-> (m_tdata[30:25] == m_tdata[6:1]) && m_tdata[0])
    else $error("highlight does not follow the tile pointed at");

  // The hover cue only comes with a hit.
  a_cue_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31] |-> m_tdata[24])
    else $error("hover cue without a hit");

endmodule

bind pointer_nearest_tile_hit_test pnth_checker u_pnth_checker (.*);

`default_nettype wire

// File: tb/pointer_nearest_tile_hit_test_tb.sv
`timescale 1ns / 1ps

module pointer_nearest_tile_hit_test_tb;
  import pnth_pkg::*;

  localparam int TILES = 64;
  localparam int SETTLE_CYCLES = 90;
  localparam int ROUNDS = 8;
  localparam int ROUND_WORDS = 210;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  // Result word, declared from the top bit down so that in_region lands in bit 0.
  typedef struct packed {
    logic        hover_cue;
    logic [5:0]  highlighted_tile;
    logic        pointing;
    logic [16:0] nearest_distance;
    logic [5:0]  nearest_tile;
    logic        in_region;
  } hit_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Mirror of the block: centre table, highlight state and registers.
  int tile_x [TILES];
  int tile_y [TILES];
  int highlight = 0;
  bit cue_given = 1'b0;
  int grid_x = 0;
  int grid_top = 0;
  int half = 0;
  int radius = 0;
  int tiles_used = 0;

  hit_result_t pending_hits[$];
  int errors = 0;
  bit quiet = 1'b0;

  pointer_nearest_tile_hit_test #(.TILE_COUNT(TILES)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Works out the word a query gives and moves the highlight state on.
  function automatic hit_result_t predict_query(input int px, input int py);
    hit_result_t r;
    int dy;
    int dx;
    int lim;
    int d;
    int best;
    int best_d;
    r = '0;
    best = 0;
    best_d = 0;
    dy = magnitude(py - (grid_top + half));
    dx = magnitude(px - grid_x);
    if (dy > half || dx > half - dy) begin
      r.highlighted_tile = highlight[5:0];
      return r;
    end
    lim = (tiles_used > TILES) ? TILES : tiles_used;
    for (int i = 0; i < lim; i++) begin
      d = magnitude(tile_x[i] - px) + magnitude(tile_y[i] - py);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    if (lim > 0) begin
      // A different closest tile re-arms the cue even when it is out of reach.
      if (best != highlight) cue_given = 1'b0;
      if (best_d <= radius) begin
        highlight = best;
        r.pointing = 1'b1;
        if (!cue_given) begin
          r.hover_cue = 1'b1;
          cue_given = 1'b1;
        end
      end
    end
    r.in_region = 1'b1;
    r.nearest_tile = best[5:0];
    r.nearest_distance = best_d[16:0];
    r.highlighted_tile = highlight[5:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    hit_result_t got;
    hit_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
      end else begin
        want = pending_hits.pop_front();
        check_field("in_region", want.in_region, got.in_region);
        check_field("nearest_tile", want.nearest_tile, got.nearest_tile);
        check_field("nearest_distance", want.nearest_distance, got.nearest_distance);
        check_field("pointing", want.pointing, got.pointing);
        check_field("highlighted_tile", want.highlighted_tile, got.highlighted_tile);
        check_field("hover_cue", want.hover_cue, got.hover_cue);
      end
    end
  end

  // Result side: a random stall before each word, none while quiet.
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_word(input logic cmd, input logic [71:0] data);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      tile_x[data[5:0]] = $signed(data[21:6]);
      tile_y[data[5:0]] = $signed(data[37:22]);
    end else begin
      pending_hits = {pending_hits,
                      predict_query($signed(data[53:38]), $signed(data[69:54]))};
    end
  endtask

  task automatic load_tile(input int slot, input int x, input int y);
    logic [31:0] junk;
    junk = $urandom;
    send_word(CMD_LOAD, {2'b00, junk[31:16], junk[15:0], y[15:0], x[15:0], slot[5:0]});
  endtask

  task automatic query_pointer(input int x, input int y);
    logic [31:0] junk_a;
    logic [31:0] junk_b;
    junk_a = $urandom;
    junk_b = $urandom;
    send_word(CMD_QUERY,
              {2'b00, y[15:0], x[15:0], junk_a[31:16], junk_a[15:0], junk_b[5:0]});
  endtask

  // Drop valid, wait for every word still owed, then give a search time to finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      CFG_GRID_CENTER_X: grid_x = $signed(value);
      CFG_GRID_TOP_Y: grid_top = $signed(value);
      CFG_DIAMOND_HALF_EXTENT: half = value[14:0];
      CFG_HIT_RADIUS: radius = value[14:0];
      CFG_TILES_IN_USE: tiles_used = value[6:0];
      default: ;
    endcase
  endtask

  // Bits above each register's width carry noise; the block must drop them.
  task automatic apply_layout(input int cx, input int ty, input int h, input int r,
                              input int t);
    logic [31:0] noise;
    settle();
    noise = $urandom;
    write_reg(CFG_GRID_CENTER_X, cx[15:0]);
    write_reg(CFG_GRID_TOP_Y, ty[15:0]);
    write_reg(CFG_DIAMOND_HALF_EXTENT, {noise[0], h[14:0]});
    write_reg(CFG_HIT_RADIUS, {noise[1], r[14:0]});
    write_reg(CFG_TILES_IN_USE, {noise[10:2], t[6:0]});
    write_reg(CFG_UNUSED, noise[31:16]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void region_point(output int x, output int y);
    int dy;
    int span;
    dy = int'($urandom_range(0, 2 * half)) - half;
    span = half - magnitude(dy);
    x = clamp16(grid_x + int'($urandom_range(0, 2 * span)) - span);
    y = clamp16(grid_top + half + dy);
  endfunction

  task automatic test_reset_state();
    // All registers at zero: the region is the single point at the origin.
    query_pointer(0, 0);
    query_pointer(1, 0);
    query_pointer(0, -1);
    query_pointer(-32768, -32768);
    query_pointer(32767, 32767);
  endtask

  task automatic test_region_edges();
    apply_layout(-32768, 32767, 32767, 0, 0);
    query_pointer(-32768, 32767);
    query_pointer(-32767, 32767);
    // The diamond reaches past the 16 bit range, so the differences must not wrap.
    apply_layout(32767, -32768, 32767, 0, 0);
    query_pointer(32767, -1);
    query_pointer(0, -1);
    query_pointer(-1, -1);
    query_pointer(32767, 32767);
    query_pointer(32767, -32768);
  endtask

  task automatic test_search_rules();
    load_tile(0, 100, 100);
    load_tile(1, 110, 100);
    load_tile(2, -32768, 32767);
    load_tile(3, 32767, -32768);
    apply_layout(100, 0, 1000, 5, 4);
    query_pointer(105, 100);   // tie between two tiles, lower index wins
    query_pointer(105, 100);   // same tile again, no second cue
    query_pointer(110, 100);   // new tile hit
    query_pointer(100, 130);   // other tile closest but out of reach
    query_pointer(110, 100);   // cue raised again after being re-armed
    query_pointer(95, 100);    // exactly at the hit radius
    query_pointer(94, 100);    // one pixel beyond it
  endtask

  task automatic test_far_corner();
    load_tile(0, -32768, -32768);
    apply_layout(32767, 0, 32767, 32767, 1);
    query_pointer(32767, 32767);
    query_pointer(-32768, 32767);
  endtask

  task automatic test_fill_table();
    logic [31:0] v;
    for (int slot = 0; slot < TILES; slot++) begin
      v = $urandom;
      load_tile(slot, $signed(v[15:0]), $signed(v[31:16]));
    end
  endtask

  task automatic test_saturated_search();
    int x;
    int y;
    apply_layout(0, -32768, 32767, 32767, 127);
    for (int i = 0; i < 3; i++) begin
      region_point(x, y);
      query_pointer(x, y);
    end
  endtask

  task automatic test_random_rounds();
    int cx, ty, h, r, t;
    int x, y, k, reach;
    logic [31:0] v;
    for (int round = 0; round < ROUNDS; round++) begin
      cx = $signed(16'($urandom));
      ty = $signed(16'($urandom));
      case ($urandom_range(0, 3))
        0: h = 32767;
        1: h = 0;
        2: h = $urandom_range(1, 64);
        default: h = $urandom_range(100, 3000);
      endcase
      case ($urandom_range(0, 3))
        0: r = 32767;
        1: r = 0;
        default: r = $urandom_range(0, 300);
      endcase
      case ($urandom_range(0, 7))
        0: t = 0;
        1: t = 1;
        2: t = 64;
        3: t = 127;
        4: t = $urandom_range(65, 126);
        default: t = $urandom_range(2, 63);
      endcase
      if (round == 0) begin
        cx = 0; ty = -32768; h = 32767; r = 32767; t = 127;
      end else if (round == 1) begin
        cx = 32767; ty = 32767; h = 0; r = 0; t = 1;
      end
      apply_layout(cx, ty, h, r, t);
      for (int n = 0; n < ROUND_WORDS; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        v = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            x = $signed(v[15:0]);
            y = $signed(v[31:16]);
          end else begin
            region_point(x, y);
          end
          load_tile($urandom_range(0, TILES - 1), x, y);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              // Aim close to a tile so that hits and cues are frequent.
              k = $urandom_range(0, TILES - 1);
              reach = ((radius > 2000) ? 2000 : radius) + 1;
              x = clamp16(tile_x[k] + int'($urandom_range(0, 2 * reach)) - reach);
              y = clamp16(tile_y[k] + int'($urandom_range(0, 2 * reach)) - reach);
            end
            5, 6, 7: region_point(x, y);
            default: begin
              x = $signed(v[15:0]);
              y = $signed(v[31:16]);
            end
          endcase
          query_pointer(x, y);
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_LOAD;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GRID_CENTER_X;
    cfg_data <= '0;
    for (int i = 0; i < TILES; i++) begin
      tile_x[i] = 0;
      tile_y[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_region_edges();
    test_search_rules();
    test_far_corner();
    test_fill_table();
    test_saturated_search();
    test_random_rounds();
    settle();
    if (errors == 0) begin
      $display("pointer_nearest_tile_hit_test_tb: clean");
    end else begin
      $display("pointer_nearest_tile_hit_test_tb: errors");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("pointer_nearest_tile_hit_test_tb: errors");
    $finish;
  end

endmodule
